// ===== hdl/pwmc_pkg.sv =====
// Package for the PWM period and duty calculator: constants, microcode types
// and the control-word table of the sequencer. No dependencies.
package pwmc_pkg;

   localparam int          CHANNELS_DEF    = 4;
   localparam logic [31:0] COUNTER_MAX_DEF = 32'd65535;
   localparam logic [31:0] CLOCK_RESET     = 32'd72000000;
   localparam logic [31:0] PRESCALER_LIMIT = 32'd65535;
   localparam logic [7:0]  DUTY_FULL       = 8'd100;
   localparam logic        KIND_DUTY       = 1'b1;
   localparam int          DIV_BITS        = 32;

   // reciprocal of DUTY_FULL, exact for products below 2**23
   localparam int          DUTY_SH         = 30;
   localparam logic [23:0] DUTY_RCP        =
      24'(((33'd1 << DUTY_SH) - 33'd1) / 33'(DUTY_FULL) + 33'd1);

   typedef logic [4:0] step_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_CLEAR,
      ACT_SAVE_FREQ,
      ACT_DIV_CLK_FREQ,
      ACT_DIV_TICKS_CMAX,
      ACT_SAVE_PRE,
      ACT_DIV_TICKS_PRE,
      ACT_SAVE_TIMER,
      ACT_DIV_DUTY,
      ACT_SAVE_CMP,
      ACT_SAVE_DUTY,
      ACT_SET_FAIL,
      ACT_REPORT,
      ACT_REPORT_NULL
   } act_type;

   typedef enum logic [3:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NO_START,
      CND_CH_BAD,
      CND_KIND_DUTY,
      CND_FREQ_SAME,
      CND_FREQ_ZERO,
      CND_DIV_BUSY,
      CND_PRE_LIMIT,
      CND_QUOT_ZERO
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type target;
   } ucode_type;

   localparam step_type ST_IDLE     = 5'd0;
   localparam step_type ST_DISP0    = 5'd1;
   localparam step_type ST_DISP1    = 5'd2;
   localparam step_type ST_DISP2    = 5'd3;
   localparam step_type ST_F_SAVE   = 5'd4;
   localparam step_type ST_F_DIV0   = 5'd5;
   localparam step_type ST_F_WAIT0  = 5'd6;
   localparam step_type ST_F_DIV1   = 5'd7;
   localparam step_type ST_F_WAIT1  = 5'd8;
   localparam step_type ST_F_PRE    = 5'd9;
   localparam step_type ST_F_DIV2   = 5'd10;
   localparam step_type ST_F_WAIT2  = 5'd11;
   localparam step_type ST_F_CHKQ   = 5'd12;
   localparam step_type ST_F_TIMER  = 5'd13;
   localparam step_type ST_C_DIV    = 5'd14;
   localparam step_type ST_C_WAIT   = 5'd15;
   localparam step_type ST_C_SAVE   = 5'd16;
   localparam step_type ST_DUTY     = 5'd17;
   localparam step_type ST_FAIL     = 5'd18;
   localparam step_type ST_REPORT   = 5'd19;
   localparam step_type ST_NULL     = 5'd20;

   // control store: action, jump condition, jump target; otherwise fall through
   function automatic ucode_type ucode_rom(step_type s);
      ucode_type w;
      case (s)
         ST_IDLE:    w = '{ACT_NONE,           CND_NO_START,  ST_IDLE};
         ST_DISP0:   w = '{ACT_CLEAR,          CND_CH_BAD,    ST_NULL};
         ST_DISP1:   w = '{ACT_NONE,           CND_KIND_DUTY, ST_DUTY};
         ST_DISP2:   w = '{ACT_NONE,           CND_FREQ_SAME, ST_REPORT};
         ST_F_SAVE:  w = '{ACT_SAVE_FREQ,      CND_FREQ_ZERO, ST_FAIL};
         ST_F_DIV0:  w = '{ACT_DIV_CLK_FREQ,   CND_NEVER,     ST_IDLE};
         ST_F_WAIT0: w = '{ACT_NONE,           CND_DIV_BUSY,  ST_F_WAIT0};
         ST_F_DIV1:  w = '{ACT_DIV_TICKS_CMAX, CND_NEVER,     ST_IDLE};
         ST_F_WAIT1: w = '{ACT_NONE,           CND_DIV_BUSY,  ST_F_WAIT1};
         ST_F_PRE:   w = '{ACT_SAVE_PRE,       CND_PRE_LIMIT, ST_FAIL};
         ST_F_DIV2:  w = '{ACT_DIV_TICKS_PRE,  CND_NEVER,     ST_IDLE};
         ST_F_WAIT2: w = '{ACT_NONE,           CND_DIV_BUSY,  ST_F_WAIT2};
         ST_F_CHKQ:  w = '{ACT_NONE,           CND_QUOT_ZERO, ST_FAIL};
         ST_F_TIMER: w = '{ACT_SAVE_TIMER,     CND_NEVER,     ST_IDLE};
         ST_C_DIV:   w = '{ACT_DIV_DUTY,       CND_NEVER,     ST_IDLE};
         ST_C_WAIT:  w = '{ACT_NONE,           CND_DIV_BUSY,  ST_C_WAIT};
         ST_C_SAVE:  w = '{ACT_SAVE_CMP,       CND_ALWAYS,    ST_REPORT};
         ST_DUTY:    w = '{ACT_SAVE_DUTY,      CND_ALWAYS,    ST_C_DIV};
         ST_FAIL:    w = '{ACT_SET_FAIL,       CND_ALWAYS,    ST_REPORT};
         ST_REPORT:  w = '{ACT_REPORT,         CND_ALWAYS,    ST_IDLE};
         ST_NULL:    w = '{ACT_REPORT_NULL,    CND_ALWAYS,    ST_IDLE};
         default:    w = '{ACT_NONE,           CND_ALWAYS,    ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/pwm_period_duty_calculator.sv =====
// PWM period and duty calculator: microcoded sequencer over a shared
// restoring divider. Depends on pwmc_pkg.
//
// Usage: a request (req_kind, req_channel, req_freq, req_duty) is taken at a
// rising edge with start high and busy low. busy stays high until the
// request's result has been issued. Each request yields one result on the
// rsp_ ports, marked by rsp_valid for exactly one cycle; the receiver cannot
// stall it. The user must write timer_clock through csr_write_en /
// csr_write_data only while the block is idle; the block does not enforce it.
// A set-frequency request that writes new settings runs two divisions on the
// shared divider (prescaler and duty compare use reciprocal multiplies); its
// search fails on a zero quotient, the prescaler limit or a zero frequency.
// A set-duty request, a repeated frequency and an unused channel run no
// division on the divider.
// busy drops in the cycle rsp_valid rises, so the next request can be taken
// then.
// Reset (synchronous, active high) returns the sequencer to idle, clears all
// channel settings and sets timer_clock to 72 MHz.
module pwm_period_duty_calculator #(
   parameter int          CHANNELS    = pwmc_pkg::CHANNELS_DEF,
   parameter logic [31:0] COUNTER_MAX = pwmc_pkg::COUNTER_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [1:0]  req_channel,
   input  logic [31:0] req_freq,
   input  logic [7:0]  req_duty,
   output logic        rsp_valid,
   output logic [1:0]  rsp_out_channel,
   output logic [15:0] rsp_prescaler,
   output logic [15:0] rsp_reload,
   output logic [15:0] rsp_compare,
   output logic        rsp_changed,
   output logic        rsp_failed,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data
);
   import pwmc_pkg::*;

   localparam int          CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int          CNT_W    = $clog2(DIV_BITS + 1);
   localparam logic [32:0] CMAX_DIV = {1'b0, COUNTER_MAX} + 33'd2;
   // reciprocal of CMAX_DIV, exact for any 32-bit tick count
   localparam int          CMAX_SH    = 32 + $clog2(CMAX_DIV);
   localparam logic [96:0] CMAX_POW   = 97'd1 << CMAX_SH;
   localparam logic [96:0] CMAX_RCP_W = (CMAX_POW - 97'd1) / 97'(CMAX_DIV) + 97'd1;
   localparam logic [32:0] CMAX_RCP   = CMAX_RCP_W[32:0];

   // sequencer
   step_type  step_ff, step_in;
   ucode_type uc;
   logic      cond_true;

   // request
   logic        kind_ff;
   logic [1:0]  chan_ff;
   logic [31:0] freq_ff;
   logic [7:0]  duty_ff;
   logic [CH_IDX_W-1:0] ch_idx;
   logic        ch_bad;

   // channel state
   logic [31:0] last_freq_ff [CHANNELS];
   logic [6:0]  last_duty_ff [CHANNELS];
   logic [15:0] pre_val_ff   [CHANNELS];
   logic [15:0] rel_val_ff   [CHANNELS];
   logic [15:0] cmp_val_ff   [CHANNELS];
   logic [31:0] timer_clock_ff;

   // datapath
   logic [31:0] ticks_ff, ticks_in;
   logic [15:0] pre_ff, pre_in;
   logic        changed_ff, changed_in;
   logic        failed_ff, failed_in;
   logic [6:0]  duty_sat;
   logic [22:0] duty_prod;
   logic [31:0] quot_m1;
   logic [96:0] cmax_prod;
   logic [46:0] duty_quot;

   // divider
   logic [31:0]      div_num_ff, div_num_in;
   logic [32:0]      div_den_ff, div_den_in;
   logic [32:0]      div_rem_ff, div_rem_in;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [33:0]      div_trial;
   logic [33:0]      div_diff;
   logic             div_ge;

   assign uc       = ucode_rom(step_ff);
   assign busy     = (step_ff != ST_IDLE);
   assign ch_idx   = CH_IDX_W'(chan_ff);
   assign ch_bad   = (32'(chan_ff) >= 32'(CHANNELS));
   assign duty_sat = (duty_ff > DUTY_FULL) ? DUTY_FULL[6:0] : duty_ff[6:0];
   assign duty_prod = rel_val_ff[ch_idx] * last_duty_ff[ch_idx];
   assign quot_m1  = div_num_ff - 32'd1;
   assign cmax_prod = 97'(div_num_ff) * 97'(CMAX_RCP);
   assign duty_quot = 47'(div_num_ff[22:0]) * 47'(DUTY_RCP);

   assign div_trial = {div_rem_ff, div_num_ff[31]};
   assign div_diff  = div_trial - {1'b0, div_den_ff};
   assign div_ge    = (div_trial >= {1'b0, div_den_ff});

   always_comb begin
      case (uc.cond)
         CND_NEVER:     cond_true = 1'b0;
         CND_ALWAYS:    cond_true = 1'b1;
         CND_NO_START:  cond_true = !start;
         CND_CH_BAD:    cond_true = ch_bad;
         CND_KIND_DUTY: cond_true = (kind_ff == KIND_DUTY);
         CND_FREQ_SAME: cond_true = (freq_ff == last_freq_ff[ch_idx]);
         CND_FREQ_ZERO: cond_true = (freq_ff == 32'd0);
         CND_DIV_BUSY:  cond_true = (div_cnt_ff != '0);
         CND_PRE_LIMIT: cond_true = (div_num_ff >= PRESCALER_LIMIT);
         CND_QUOT_ZERO: cond_true = (div_num_ff == 32'd0);
         default:       cond_true = 1'b0;
      endcase
      step_in = cond_true ? uc.target : step_type'(step_ff + 5'd1);
   end

   always_comb begin
      ticks_in   = ticks_ff;
      pre_in     = pre_ff;
      changed_in = changed_ff;
      failed_in  = failed_ff;
      div_num_in = div_num_ff;
      div_den_in = div_den_ff;
      div_rem_in = div_rem_ff;
      div_cnt_in = div_cnt_ff;
      if (div_cnt_ff != '0) begin
         div_rem_in = div_ge ? div_diff[32:0] : div_trial[32:0];
         div_num_in = {div_num_ff[30:0], div_ge};
         div_cnt_in = div_cnt_ff - CNT_W'(1);
      end
      case (uc.act)
         ACT_CLEAR: begin
            changed_in = 1'b0;
            failed_in  = 1'b0;
         end
         ACT_DIV_CLK_FREQ: begin
            div_num_in = timer_clock_ff;
            div_den_in = {1'b0, freq_ff};
            div_rem_in = '0;
            div_cnt_in = CNT_W'(DIV_BITS);
         end
         ACT_DIV_TICKS_CMAX: begin
            ticks_in   = div_num_ff;
            div_num_in = cmax_prod[CMAX_SH +: 32];
         end
         ACT_SAVE_PRE: pre_in = div_num_ff[15:0];
         ACT_DIV_TICKS_PRE: begin
            div_num_in = ticks_ff;
            div_den_in = 33'(pre_ff) + 33'd1;
            div_rem_in = '0;
            div_cnt_in = CNT_W'(DIV_BITS);
         end
         ACT_DIV_DUTY:  div_num_in = 32'(duty_prod);
         ACT_SAVE_CMP:  changed_in = 1'b1;
         ACT_SAVE_DUTY: changed_in = 1'b1;
         ACT_SET_FAIL:  failed_in  = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= ST_IDLE;
         div_cnt_ff     <= '0;
         rsp_valid      <= 1'b0;
         timer_clock_ff <= CLOCK_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            last_freq_ff[i] <= '0;
            last_duty_ff[i] <= '0;
            pre_val_ff[i]   <= '0;
            rel_val_ff[i]   <= '0;
            cmp_val_ff[i]   <= '0;
         end
      end else begin
         step_ff    <= step_in;
         div_cnt_ff <= div_cnt_in;
         rsp_valid  <= (uc.act == ACT_REPORT) || (uc.act == ACT_REPORT_NULL);
         if (csr_write_en) begin
            timer_clock_ff <= csr_write_data;
         end
         case (uc.act)
            ACT_SAVE_FREQ: last_freq_ff[ch_idx] <= freq_ff;
            ACT_SAVE_TIMER: begin
               pre_val_ff[ch_idx] <= pre_ff;
               rel_val_ff[ch_idx] <= quot_m1[15:0];
            end
            ACT_SAVE_CMP:  cmp_val_ff[ch_idx]   <= duty_quot[DUTY_SH +: 16];
            ACT_SAVE_DUTY: last_duty_ff[ch_idx] <= duty_sat;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ticks_ff   <= ticks_in;
      pre_ff     <= pre_in;
      changed_ff <= changed_in;
      failed_ff  <= failed_in;
      div_num_ff <= div_num_in;
      div_den_ff <= div_den_in;
      div_rem_ff <= div_rem_in;
      if (step_ff == ST_IDLE && start) begin
         kind_ff <= req_kind;
         chan_ff <= req_channel;
         freq_ff <= req_freq;
         duty_ff <= req_duty;
      end
      if (uc.act == ACT_REPORT) begin
         rsp_out_channel <= chan_ff;
         rsp_prescaler   <= pre_val_ff[ch_idx];
         rsp_reload      <= rel_val_ff[ch_idx];
         rsp_compare     <= cmp_val_ff[ch_idx];
         rsp_changed     <= changed_ff;
         rsp_failed      <= failed_ff;
      end else if (uc.act == ACT_REPORT_NULL) begin
         rsp_out_channel <= chan_ff;
         rsp_prescaler   <= '0;
         rsp_reload      <= '0;
         rsp_compare     <= '0;
         rsp_changed     <= 1'b0;
         rsp_failed      <= 1'b0;
      end
   end

endmodule

// ===== tb/sv/tb_pwm_period_duty_calculator.sv =====
// Self-checking testbench for pwm_period_duty_calculator: directed and random
// set-frequency and set-duty requests over several timer clock settings.
// Depends on pwmc_pkg and the pwm_period_duty_calculator RTL.
module tb_pwm_period_duty_calculator;
   import pwmc_pkg::*;

   localparam int   STALL_LIMIT   = 4000;
   localparam int   TAIL_CYCLES   = 200;
   localparam int   RANDOM_PHASES = 8;
   localparam int   PHASE_ITEMS   = 225;
   localparam logic KIND_FREQ     = ~KIND_DUTY;

   typedef struct packed {
      logic [1:0]  channel;
      logic [15:0] prescaler;
      logic [15:0] reload;
      logic [15:0] compare;
      logic        changed;
      logic        failed;
   } pwm_settings_type;

   class pwm_channel_scoreboard;
      logic [31:0]      timer_clock;
      logic [31:0]      last_frequency [CHANNELS_DEF];
      logic [6:0]       last_duty [CHANNELS_DEF];
      logic [15:0]      prescaler_value [CHANNELS_DEF];
      logic [15:0]      reload_value [CHANNELS_DEF];
      logic [15:0]      compare_value [CHANNELS_DEF];
      pwm_settings_type pending_settings [$];
      int               errors;
      int               freq_requests;
      int               duty_requests;
      int               failed_searches;
      int               repeated_freqs;
      int               clock_writes;

      function new();
         timer_clock = CLOCK_RESET;
         for (int i = 0; i < CHANNELS_DEF; i++) begin
            last_frequency[i]  = '0;
            last_duty[i]       = '0;
            prescaler_value[i] = '0;
            reload_value[i]    = '0;
            compare_value[i]   = '0;
         end
         errors          = 0;
         freq_requests   = 0;
         duty_requests   = 0;
         failed_searches = 0;
         repeated_freqs  = 0;
         clock_writes    = 0;
      endfunction

      function void set_clock(logic [31:0] value);
         timer_clock = value;
         clock_writes++;
      endfunction

      function logic [15:0] duty_compare(logic [15:0] reload, logic [6:0] duty);
         logic [31:0] prod;
         prod = 32'(reload) * 32'(duty);
         return 16'(prod / 32'(DUTY_FULL));
      endfunction

      function pwm_settings_type compute_settings(logic kind, logic [1:0] ch,
                                                  logic [31:0] freq, logic [7:0] duty);
         pwm_settings_type r;
         logic [31:0]      ticks;
         logic [31:0]      pre;
         logic [31:0]      quot;
         logic [7:0]       sat;
         r = '0;
         r.channel = ch;
         if (int'(ch) >= CHANNELS_DEF) return r;
         if (kind == KIND_DUTY) begin
            duty_requests++;
            sat = (duty > DUTY_FULL) ? DUTY_FULL : duty;
            last_duty[ch] = sat[6:0];
            compare_value[ch] = duty_compare(reload_value[ch], sat[6:0]);
            r.changed = 1'b1;
         end else begin
            freq_requests++;
            if (freq == last_frequency[ch]) begin
               repeated_freqs++;
            end else begin
               last_frequency[ch] = freq;
               r.failed = 1'b1;
               if (freq != 0) begin
                  ticks = timer_clock / freq;
                  pre = ticks / (COUNTER_MAX_DEF + 32'd2);
                  if (pre < PRESCALER_LIMIT) begin
                     quot = ticks / (pre + 32'd1);
                     if (quot != 0) begin
                        prescaler_value[ch] = pre[15:0];
                        reload_value[ch] = 16'(quot - 32'd1);
                        compare_value[ch] = duty_compare(reload_value[ch], last_duty[ch]);
                        r.failed  = 1'b0;
                        r.changed = 1'b1;
                     end
                  end
               end
               if (r.failed) failed_searches++;
            end
         end
         r.prescaler = prescaler_value[ch];
         r.reload    = reload_value[ch];
         r.compare   = compare_value[ch];
         return r;
      endfunction

      function void note_request(logic kind, logic [1:0] ch, logic [31:0] freq,
                                 logic [7:0] duty);
         pending_settings.push_back(compute_settings(kind, ch, freq, duty));
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch: %s got 0x%0h expected 0x%0h", what, got, want);
         errors++;
      endtask

      task check_result(pwm_settings_type got);
         pwm_settings_type want;
         if (pending_settings.size() == 0) begin
            report_mismatch("result with no request outstanding", 32'(got), 0);
         end else begin
            want = pending_settings.pop_front();
            if (got.channel != want.channel)
               report_mismatch("out_channel", 32'(got.channel), 32'(want.channel));
            if (got.prescaler != want.prescaler)
               report_mismatch("prescaler", 32'(got.prescaler), 32'(want.prescaler));
            if (got.reload != want.reload)
               report_mismatch("reload", 32'(got.reload), 32'(want.reload));
            if (got.compare != want.compare)
               report_mismatch("compare", 32'(got.compare), 32'(want.compare));
            if (got.changed != want.changed)
               report_mismatch("changed", 32'(got.changed), 32'(want.changed));
            if (got.failed != want.failed)
               report_mismatch("failed", 32'(got.failed), 32'(want.failed));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_kind;
   logic [1:0]  req_channel;
   logic [31:0] req_freq;
   logic [7:0]  req_duty;
   logic        rsp_valid;
   logic [1:0]  rsp_out_channel;
   logic [15:0] rsp_prescaler;
   logic [15:0] rsp_reload;
   logic [15:0] rsp_compare;
   logic        rsp_changed;
   logic        rsp_failed;
   logic        csr_write_en;
   logic [31:0] csr_write_data;

   pwm_channel_scoreboard sb;

   pwm_period_duty_calculator dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result('{rsp_out_channel, rsp_prescaler, rsp_reload, rsp_compare,
                           rsp_changed, rsp_failed});
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || rsp_valid || (start && !busy)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("pwm_period_duty_calculator verification failed");
      $finish;
   end

   task automatic send_request(logic kind, logic [1:0] ch, logic [31:0] freq,
                               logic [7:0] duty, int gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start       <= 1'b1;
      req_kind    <= kind;
      req_channel <= ch;
      req_freq    <= freq;
      req_duty    <= duty;
      do @(posedge clock); while (busy);
      sb.note_request(kind, ch, freq, duty);
   endtask

   task automatic directed(logic kind, logic [1:0] ch, logic [31:0] freq, logic [7:0] duty);
      send_request(kind, ch, freq, duty, $urandom_range(0, 14));
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_settings.size() != 0) @(posedge clock);
   endtask

   task automatic write_clock(logic [31:0] value);
      drain_results();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      sb.set_clock(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [31:0] pick_freq(logic [1:0] ch);
      logic [31:0] clk_hz;
      logic [31:0] divisor;
      clk_hz = sb.timer_clock;
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return sb.last_frequency[ch];
         2, 3:    return $urandom();
         4, 5:    return $urandom_range(1, 2000);
         9:       return clk_hz + 32'($urandom_range(0, 2)) - 32'd1;
         default: begin
            divisor = $urandom_range(1, 32'hFFFF_FFFF >> $urandom_range(0, 31));
            return (clk_hz / divisor) + 32'($urandom_range(0, 1));
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_clock();
      case ($urandom_range(0, 5))
         0:       return CLOCK_RESET;
         1:       return 32'd1;
         2:       return 32'hFFFF_FFFF;
         3:       return $urandom();
         default: return $urandom_range(1000, 250_000_000);
      endcase
   endfunction

   initial begin : stimulus
      logic       kind;
      logic [1:0] ch;
      logic [7:0] duty;
      int         gap;
      reset          = 1'b1;
      start          = 1'b0;
      req_kind       = 1'b0;
      req_channel    = '0;
      req_freq       = '0;
      req_duty       = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default 72 MHz clock
      directed(KIND_FREQ, 2'd0, 32'd0, 8'd0);           // zero right after reset: repeat
      directed(KIND_DUTY, 2'd0, 32'd0, 8'd50);
      directed(KIND_FREQ, 2'd0, 32'd1000, 8'd0);
      directed(KIND_FREQ, 2'd0, 32'd1000, 8'd255);      // repeated frequency
      directed(KIND_FREQ, 2'd0, 32'd0, 8'd0);           // zero frequency fails
      directed(KIND_FREQ, 2'd0, 32'd0, 8'd0);           // same zero again: no failure
      directed(KIND_FREQ, 2'd1, 32'd100_000_000, 8'd0); // above clock: no fit
      directed(KIND_FREQ, 2'd1, CLOCK_RESET, 8'd0);     // reload 0
      directed(KIND_DUTY, 2'd1, 32'd0, 8'd255);         // saturated duty
      directed(KIND_DUTY, 2'd2, 32'hFFFF_FFFF, 8'd100);
      directed(KIND_DUTY, 2'd3, 32'd0, 8'd0);
      directed(KIND_FREQ, 2'd2, 32'd1, 8'd0);
      directed(KIND_DUTY, 2'd2, 32'd0, 8'd101);
      directed(KIND_FREQ, 2'd3, 32'hFFFF_FFFF, 8'd0);
      directed(KIND_FREQ, 2'd3, 32'd1099, 8'd0);
      // largest clock: prescaler limit reached at 1 Hz
      write_clock(32'hFFFF_FFFF);
      directed(KIND_FREQ, 2'd0, 32'd1, 8'd0);
      directed(KIND_FREQ, 2'd0, 32'd2, 8'd0);
      directed(KIND_FREQ, 2'd1, 32'hFFFF_FFFF, 8'd0);
      directed(KIND_DUTY, 2'd0, 32'd0, 8'd99);
      // zero clock: every search fails
      write_clock(32'd0);
      directed(KIND_FREQ, 2'd2, 32'd5, 8'd0);
      directed(KIND_DUTY, 2'd2, 32'd0, 8'd33);
      // smallest nonzero clock
      write_clock(32'd1);
      directed(KIND_FREQ, 2'd3, 32'd1, 8'd0);
      directed(KIND_FREQ, 2'd3, 32'd2, 8'd0);
      directed(KIND_DUTY, 2'd3, 32'd0, 8'd100);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_clock(pick_clock());
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            kind = ($urandom_range(0, 99) < 55) ? KIND_FREQ : KIND_DUTY;
            ch   = 2'($urandom_range(0, 3));
            duty = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 100))
                                               : 8'($urandom_range(101, 255));
            gap  = ((i % 100) < 30) ? 0 : $urandom_range(0, 14);
            send_request(kind, ch, (kind == KIND_FREQ) ? pick_freq(ch) : $urandom(),
                         duty, gap);
            if ($urandom_range(0, 149) == 0) drain_results();
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending_settings.size() != 0)
         sb.report_mismatch("results never issued", sb.pending_settings.size(), 0);
      $display("run covered %0d set-frequency and %0d set-duty requests, %0d clock writes",
               sb.freq_requests, sb.duty_requests, sb.clock_writes);
      $display("%0d failed searches, %0d repeated frequencies, %0d mismatches",
               sb.failed_searches, sb.repeated_freqs, sb.errors);
      if (sb.errors == 0)
         $display("pwm_period_duty_calculator verification clean");
      else
         $display("pwm_period_duty_calculator verification failed");
      $finish;
   end

endmodule
